// ===== rtl/efd_pkg.sv =====
// efd_pkg: shared constants, widths and controller/datapath interface types
// for the escaped frame decoder. No dependencies.
package efd_pkg;

   localparam int MAX_FRAME_DEF = 64;

   localparam int BYTE_W     = 8;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 6;
   localparam int LEN_W      = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 24;

   localparam logic [BYTE_W-1:0] ESC_BYTE   = 8'hD5;
   localparam logic [BYTE_W-1:0] LIT_CODE   = 8'h5D;
   localparam logic [BYTE_W-1:0] REMAP_XOR  = 8'hAA;
   localparam logic [BYTE_W-1:0] SEED_RESET = 8'hA5;

   localparam logic [STATUS_W-1:0] ST_GOOD     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADLEN   = 2'd2;

   typedef struct packed {
      logic table_wr;
      logic store;
      logic lit;
      logic capture;
      logic end_frame;
      logic out_good;
      logic out_err;
      logic err_mismatch;
   } efd_cmd_type;

   typedef struct packed {
      logic is_load;
      logic is_esc;
      logic is_lit;
      logic room;
      logic len_bad;
      logic chk_ok;
      logic pos_last;
      logic out_free;
   } efd_stat_type;

endpackage

// ===== rtl/efd_ctrl.sv =====
// efd_ctrl: frame decoder state machine, escape tracking and command issue.
// Depends on efd_pkg.
module efd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  efd_pkg::efd_stat_type stat,
   output efd_pkg::efd_cmd_type  cmd
);
   import efd_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_LOOK = 3'd1;
   localparam logic [2:0] S_ERR  = 3'd2;
   localparam logic [2:0] S_RD   = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       armed_ff, armed_in;
   logic       mis_ff, mis_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      armed_in = armed_ff;
      mis_in   = mis_ff;
      cmd      = '0;
      cmd.err_mismatch = mis_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (stat.is_load) begin
                  cmd.table_wr = 1'b1;
               end else if (stat.is_esc) begin
                  armed_in = 1'b1;
               end else if (armed_ff && !stat.is_lit) begin
                  armed_in      = 1'b0;
                  cmd.end_frame = 1'b1;
                  if (stat.len_bad) begin
                     mis_in   = 1'b0;
                     state_in = S_ERR;
                  end else if (!stat.chk_ok) begin
                     mis_in   = 1'b1;
                     state_in = S_ERR;
                  end else begin
                     state_in = S_RD;
                  end
               end else begin
                  armed_in  = 1'b0;
                  cmd.store = 1'b1;
                  cmd.lit   = armed_ff;
                  if (stat.room) begin
                     state_in = S_LOOK;
                  end
               end
            end
         end
         S_LOOK: begin
            cmd.capture = 1'b1;
            state_in    = S_IDLE;
         end
         S_ERR: begin
            if (stat.out_free) begin
               cmd.out_err = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_RD: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.out_good = 1'b1;
               state_in     = stat.pos_last ? S_IDLE : S_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         armed_ff <= 1'b0;
         mis_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         armed_ff <= armed_in;
         mis_ff   <= mis_in;
      end
   end

endmodule

// ===== rtl/efd_datapath.sv =====
// efd_datapath: substitution table and payload memories, byte count, running
// checksum, seed register and result output register. Depends on efd_pkg.
module efd_datapath #(
   parameter int MAX_FRAME = efd_pkg::MAX_FRAME_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [efd_pkg::BYTE_W-1:0]      csr_wr_data,
   input  logic [efd_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tuser,
   input  efd_pkg::efd_cmd_type            cmd,
   output efd_pkg::efd_stat_type           stat,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [efd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [efd_pkg::STATUS_W-1:0]    rsp_tuser,
   output logic                            rsp_tlast
);
   import efd_pkg::*;

   localparam int AW    = $clog2(MAX_FRAME);
   localparam int CNT_W = $clog2(MAX_FRAME + 2);

   logic [BYTE_W-1:0] tbl_ff [256];
   logic [BYTE_W-1:0] pay_ff [MAX_FRAME];
   logic [BYTE_W-1:0] tbl_rd_ff;
   logic [BYTE_W-1:0] pay_rd_ff;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    len_ff, len_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [BYTE_W-1:0]   check_ff, check_in;
   logic [BYTE_W-1:0]   seed_ff, seed_in;

   logic                out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0] out_status_ff, out_status_in;
   logic [BYTE_W-1:0]   out_byte_ff, out_byte_in;
   logic [POS_W-1:0]    out_pos_ff, out_pos_in;
   logic [LEN_W-1:0]    out_len_ff, out_len_in;
   logic                out_last_ff, out_last_in;

   logic [BYTE_W-1:0] byte_value;
   logic [BYTE_W-1:0] table_index;
   logic [BYTE_W-1:0] v_eff;
   logic [BYTE_W-1:0] base;
   logic [BYTE_W-1:0] rd_addr;
   logic [BYTE_W-1:0] chk_rm;

   assign byte_value  = req_tdata[BYTE_W-1:0];
   assign table_index = req_tdata[2*BYTE_W-1:BYTE_W];
   assign v_eff       = cmd.lit ? ESC_BYTE : byte_value;
   assign base        = (count_ff == '0) ? seed_ff : check_ff;
   assign rd_addr     = base + v_eff;
   assign chk_rm      = ((check_ff == LIT_CODE) || (check_ff == ESC_BYTE)) ?
                        (check_ff ^ REMAP_XOR) : check_ff;

   always_comb begin
      stat          = '0;
      stat.is_load  = req_tuser;
      stat.is_esc   = (byte_value == ESC_BYTE);
      stat.is_lit   = (byte_value == LIT_CODE);
      stat.room     = (count_ff < CNT_W'(MAX_FRAME));
      stat.len_bad  = (count_ff == '0) || (count_ff > CNT_W'(MAX_FRAME));
      stat.chk_ok   = (chk_rm == byte_value);
      stat.pos_last = ((CNT_W'(pos_ff) + CNT_W'(1)) == len_ff);
      stat.out_free = !out_valid_ff || rsp_tready;
   end

   // memories, registered read
   always_ff @(posedge clock) begin
      if (cmd.table_wr) begin
         tbl_ff[table_index] <= byte_value;
      end
      tbl_rd_ff <= tbl_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.store && stat.room) begin
         pay_ff[count_ff[AW-1:0]] <= v_eff;
      end
      pay_rd_ff <= pay_ff[pos_ff];
   end

   always_comb begin
      count_in = count_ff;
      len_in   = len_ff;
      pos_in   = pos_ff;
      check_in = check_ff;
      seed_in  = seed_ff;
      if (csr_wr_en) begin
         seed_in = csr_wr_data;
      end
      if (cmd.end_frame) begin
         count_in = '0;
         len_in   = count_ff;
         pos_in   = '0;
         check_in = seed_ff;
      end else if (cmd.store) begin
         count_in = stat.room ? (count_ff + CNT_W'(1)) : CNT_W'(MAX_FRAME + 1);
      end
      if (cmd.capture) begin
         check_in = tbl_rd_ff;
      end
      if (cmd.out_good) begin
         pos_in = pos_ff + AW'(1);
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_status_in = out_status_ff;
      out_byte_in   = out_byte_ff;
      out_pos_in    = out_pos_ff;
      out_len_in    = out_len_ff;
      out_last_in   = out_last_ff;
      if (cmd.out_good) begin
         out_valid_in  = 1'b1;
         out_status_in = ST_GOOD;
         out_byte_in   = pay_rd_ff;
         out_pos_in    = POS_W'(pos_ff);
         out_len_in    = LEN_W'(len_ff);
         out_last_in   = stat.pos_last;
      end else if (cmd.out_err) begin
         out_valid_in  = 1'b1;
         out_status_in = cmd.err_mismatch ? ST_MISMATCH : ST_BADLEN;
         out_byte_in   = '0;
         out_pos_in    = '0;
         out_len_in    = cmd.err_mismatch ? LEN_W'(len_ff) : '0;
         out_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         len_ff       <= '0;
         pos_ff       <= '0;
         check_ff     <= SEED_RESET;
         seed_ff      <= SEED_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         len_ff       <= len_in;
         pos_ff       <= pos_in;
         check_ff     <= check_in;
         seed_ff      <= seed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff <= out_status_in;
      out_byte_ff   <= out_byte_in;
      out_pos_ff    <= out_pos_in;
      out_len_ff    <= out_len_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - BYTE_W - POS_W - LEN_W){1'b0}},
                        out_len_ff, out_pos_ff, out_byte_ff};

endmodule

// ===== rtl/escaped_frame_decoder_unit.sv =====
// Escaped frame decoder, top level: joins the controller and the datapath.
// Depends on efd_pkg, efd_ctrl and efd_datapath.
//
// Decodes a stream of link bytes into frames. 0xD5 arms an escape; an armed
// 0x5D is a literal 0xD5 payload byte and any other armed byte but 0xD5 ends the frame
// and carries its checksum. The checksum runs each stored byte through a
// 256-entry substitution table, which must be loaded through table-load words
// (tuser high) before frames are sent; it has no reset and no clearing pass.
// A good frame comes out as one word per payload byte with tlast on the final
// one; an empty, overlong or mismatching frame gives a single error word.
// Escape bytes, table loads and dropped overlong bytes are taken in the idle state
// alone; a stored payload byte adds a capture state for the registered read of the
// substitution table. A good frame end steps through a read state (registered read
// of the payload store) and an emit state per output word before the next byte is
// taken; an error frame end waits in an error state for the output register.
module escaped_frame_decoder_unit #(
   parameter int MAX_FRAME = efd_pkg::MAX_FRAME_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [efd_pkg::BYTE_W-1:0]      csr_wr_data,  // checksum_seed
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [efd_pkg::REQ_DATA_W-1:0]  req_tdata,    // byte_value, table_index
   input  logic                            req_tuser,    // func
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [efd_pkg::RSP_DATA_W-1:0]  rsp_tdata,    // payload_byte, byte_position, frame_length
   output logic [efd_pkg::STATUS_W-1:0]    rsp_tuser,    // status
   output logic                            rsp_tlast     // last
);
   import efd_pkg::*;

   efd_cmd_type  cmd;
   efd_stat_type stat;

   efd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   efd_datapath #(
      .MAX_FRAME (MAX_FRAME)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

// ===== rtl/efd_checker.sv =====
// efd_checker: port-level checks on the result stream of the decoder, bound
// to escaped_frame_decoder_unit. Depends on efd_pkg.
module efd_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [efd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic [efd_pkg::STATUS_W-1:0]    rsp_tuser,
   input  logic                            rsp_tlast
);
   import efd_pkg::*;

   logic [BYTE_W-1:0] pay;
   logic [POS_W-1:0]  pos;
   logic [LEN_W-1:0]  len;

   assign pay = rsp_tdata[BYTE_W-1:0];
   assign pos = rsp_tdata[BYTE_W+POS_W-1:BYTE_W];
   assign len = rsp_tdata[BYTE_W+POS_W+LEN_W-1:BYTE_W+POS_W];

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // error word is a single closing word with no payload
   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_GOOD) |-> rsp_tlast && (pay == '0) && (pos == '0))
      else $error("malformed error word");

   // good word lies inside its frame
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_GOOD) |-> (len != '0) && ({1'b0, pos} < len))
      else $error("good word outside frame length");

   // tlast marks exactly the final byte of a good frame
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_GOOD) |->
         (rsp_tlast == (({1'b0, pos} + LEN_W'(1)) == len)))
      else $error("tlast not on final byte");

endmodule

bind escaped_frame_decoder_unit efd_checker u_efd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== sim/tb_escaped_frame_decoder_unit.sv =====
// testbench for escaped_frame_decoder_unit: table load, directed rows, then random frames
// checked word by word against a predictor of the frame decoder
// depends on efd_pkg and the escaped_frame_decoder_unit rtl
`timescale 1ns / 1ps

module tb_escaped_frame_decoder_unit;
   import efd_pkg::*;

   localparam int MAX_FRAME   = MAX_FRAME_DEF;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASE_WORDS = 8;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   payload;
      logic [POS_W-1:0]    pos;
      logic [LEN_W-1:0]    len;
      logic                last;
   } frame_word_type;

   typedef enum logic [2:0] {
      ROW_LINK, ROW_LOAD, ROW_SEED, ROW_END, ROW_END_OK, ROW_END_BAD, ROW_HOLD
   } row_kind_type;

   typedef struct {
      row_kind_type        kind;
      logic [BYTE_W-1:0]   value;
      logic [BYTE_W-1:0]   index;
      int                  count;
      bit                  typed;
      logic [STATUS_W-1:0] status;
   } stim_row_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  csr_wr_en   = 1'b0;
   logic [BYTE_W-1:0]     csr_wr_data = '0;
   logic                  req_tvalid  = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata   = '0;
   logic                  req_tuser   = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]   rsp_tuser;
   logic                  rsp_tlast;

   // predictor state
   logic [BYTE_W-1:0] sub_table [256];
   logic [BYTE_W-1:0] frame_bytes [MAX_FRAME];
   int                link_count  = 0;
   bit                esc_pending = 1'b0;
   logic [BYTE_W-1:0] chk_acc     = SEED_RESET;
   logic [BYTE_W-1:0] seed_value  = SEED_RESET;

   frame_word_type produced_words [$];
   frame_word_type pending_words [$];

   int errors        = 0;
   int items_sent    = 0;
   int cycle_count   = 0;
   int hold_requests = 0;
   int holds_started = 0;
   bit steady        = 1'b0;

   stim_row_type directed_rows [28] = '{
      '{ROW_END,     8'h00,    8'h00, 1,  1'b1, ST_BADLEN},
      '{ROW_LINK,    ESC_BYTE, 8'h00, 3,  1'b0, ST_GOOD},
      '{ROW_END,     8'hFF,    8'h00, 1,  1'b1, ST_BADLEN},
      '{ROW_LOAD,    LIT_CODE, 8'hA5, 1,  1'b0, ST_GOOD},
      '{ROW_LOAD,    ESC_BYTE, 8'hA6, 1,  1'b0, ST_GOOD},
      '{ROW_LINK,    8'h00,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_END_OK,  8'h00,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_LINK,    8'h01,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_END_OK,  8'h00,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_LOAD,    8'hFF,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_LOAD,    8'h00,    8'hFF, 1,  1'b0, ST_GOOD},
      '{ROW_LINK,    8'hFF,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_LINK,    ESC_BYTE, 8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_LINK,    LIT_CODE, 8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_LOAD,    8'h3C,    8'h7E, 1,  1'b0, ST_GOOD},
      '{ROW_LINK,    LIT_CODE, 8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_END_OK,  8'h00,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_LINK,    8'h7E,    8'h00, 2,  1'b0, ST_GOOD},
      '{ROW_END_BAD, 8'h00,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_LINK,    8'h11,    8'h00, 64, 1'b0, ST_GOOD},
      '{ROW_HOLD,    8'h00,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_END_OK,  8'h00,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_LINK,    8'hEE,    8'h00, 65, 1'b0, ST_GOOD},
      '{ROW_END,     8'h00,    8'h00, 1,  1'b1, ST_BADLEN},
      '{ROW_LINK,    8'h42,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_SEED,    8'h00,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_LINK,    8'h24,    8'h00, 1,  1'b0, ST_GOOD},
      '{ROW_END_OK,  8'h00,    8'h00, 1,  1'b0, ST_GOOD}
   };

   escaped_frame_decoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // byte_value, table_index
      .req_tuser   (req_tuser),   // func
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // payload_byte, byte_position, frame_length
      .rsp_tuser   (rsp_tuser),   // status
      .rsp_tlast   (rsp_tlast)    // last
   );

   always #5 clock = ~clock;

   // checksum byte that closes the current frame, remapped off the escape codes
   function automatic logic [BYTE_W-1:0] frame_check();
      logic [BYTE_W-1:0] c;
      c = chk_acc;
      if (c == LIT_CODE || c == ESC_BYTE) c = c ^ REMAP_XOR;
      return c;
   endfunction

   function automatic void decode_link_word(input logic func, input logic [BYTE_W-1:0] v,
                                            input logic [BYTE_W-1:0] idx);
      logic [BYTE_W-1:0] data;
      logic [BYTE_W-1:0] chk;
      int n;
      produced_words.delete();
      data = v;
      if (func) begin
         sub_table[idx] = v;
         return;
      end
      if (v == ESC_BYTE) begin
         esc_pending = 1'b1;
         return;
      end
      if (esc_pending) begin
         esc_pending = 1'b0;
         if (v == LIT_CODE) begin
            data = ESC_BYTE;
         end else begin
            n   = link_count;
            chk = frame_check();
            link_count = 0;
            chk_acc    = seed_value;
            if (n == 0 || n > MAX_FRAME) begin
               produced_words.push_back('{ST_BADLEN, 8'h00, 6'd0, 7'd0, 1'b1});
            end else if (chk != v) begin
               produced_words.push_back('{ST_MISMATCH, 8'h00, 6'd0, 7'(n), 1'b1});
            end else begin
               for (int i = 0; i < n; i++)
                  produced_words.push_back('{ST_GOOD, frame_bytes[i], 6'(i), 7'(n),
                                             1'(i == n - 1)});
            end
            return;
         end
      end
      if (link_count < MAX_FRAME) begin
         chk = (link_count == 0) ? seed_value : chk_acc;
         frame_bytes[link_count] = data;
         chk_acc = sub_table[8'(chk + data)];
         link_count++;
      end else begin
         link_count = MAX_FRAME + 1;
      end
   endfunction

   // mostly short gaps, a few long ones, none in a steady stretch
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(15, 50);
   endfunction

   task automatic send_word(input logic func, input logic [BYTE_W-1:0] v,
                            input logic [BYTE_W-1:0] idx, input bit use_typed = 1'b0,
                            input frame_word_type typed_word = '0);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {idx, v};
      do @(posedge clock); while (!req_tready);
      decode_link_word(func, v, idx);
      if (use_typed) pending_words.push_back(typed_word);
      else foreach (produced_words[i]) pending_words.push_back(produced_words[i]);
      items_sent++;
   endtask

   task automatic close_frame(input row_kind_type kind, input logic [BYTE_W-1:0] v,
                              input bit use_typed = 1'b0,
                              input frame_word_type typed_word = '0);
      logic [BYTE_W-1:0] b;
      send_word(1'b0, ESC_BYTE, 8'($urandom_range(0, 255)));
      b = v;
      if (kind == ROW_END_OK) b = frame_check();
      if (kind == ROW_END_BAD) begin
         b = frame_check() + 8'd1;
         if (b == ESC_BYTE || b == LIT_CODE) b = b + 8'd1;
      end
      send_word(1'b0, b, 8'($urandom_range(0, 255)), use_typed, typed_word);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   // start a long receiver hold and go on once it is in force
   task automatic request_hold();
      req_tvalid <= 1'b0;
      hold_requests++;
      wait (holds_started == hold_requests);
   endtask

   task automatic write_seed(input logic [BYTE_W-1:0] s);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= s;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      seed_value = s;
   endtask

   task automatic send_random_frame();
      int r;
      int n;
      logic [BYTE_W-1:0] b;
      r = $urandom_range(0, 99);
      if (r < 5) n = 0;
      else if (r < 7) n = $urandom_range(MAX_FRAME + 1, MAX_FRAME + 3);
      else if (r < 12) n = $urandom_range(30, MAX_FRAME);
      else n = $urandom_range(1, 10);
      // stray words and broken sequences
      if ($urandom_range(0, 99) < 6)
         repeat ($urandom_range(1, 5))
            send_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 4)
            send_word(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
         r = $urandom_range(0, 99);
         b = (r < 12) ? ESC_BYTE : (r < 20) ? LIT_CODE : 8'($urandom_range(0, 255));
         if (b == ESC_BYTE) send_word(1'b0, ESC_BYTE, 8'($urandom_range(0, 255)));
         send_word(1'b0, (b == ESC_BYTE) ? LIT_CODE : b, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 99) < 10)
         repeat ($urandom_range(1, 3)) send_word(1'b0, ESC_BYTE, 8'($urandom_range(0, 255)));
      close_frame(($urandom_range(0, 99) < 85) ? ROW_END_OK : ROW_END_BAD, 8'h00);
   endtask

   initial begin : stimulus
      stim_row_type      row;
      int                phase_start;
      logic [BYTE_W-1:0] new_seed;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // substitution table has no reset, fill every entry first
      for (int i = 0; i < 256; i++)
         send_word(1'b1, 8'($urandom_range(0, 255)), 8'(i));

      foreach (directed_rows[r]) begin
         row = directed_rows[r];
         case (row.kind)
            ROW_LINK: repeat (row.count) send_word(1'b0, row.value, 8'($urandom_range(0, 255)));
            ROW_LOAD: send_word(1'b1, row.value, row.index);
            ROW_SEED: write_seed(row.value);
            ROW_HOLD: request_hold();
            default:  close_frame(row.kind, row.value, row.typed,
                                  '{row.status, 8'h00, 6'd0, 7'd0, 1'b1});
         endcase
      end

      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       new_seed = 8'h00;
            1:       new_seed = 8'hFF;
            default: new_seed = 8'($urandom_range(0, 255));
         endcase
         write_seed(new_seed);
         steady = (p == 2);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_WORDS) send_random_frame();
      end
      steady = 1'b0;

      drain();
      if (errors == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end

   initial begin : rsp_ready_driver
      int n;
      wait (!reset);
      forever begin
         if (holds_started != hold_requests) begin
            // long back-pressure so the decoder fills up and stalls its input
            holds_started++;
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         n = idle_length();
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : rsp_monitor
      frame_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            $error("word with none expected: status %0d payload %0h", rsp_tuser, rsp_tdata[7:0]);
            errors++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[7:0] !== want.payload) begin
               $error("payload_byte: expected %0h, got %0h", want.payload, rsp_tdata[7:0]);
               errors++;
            end
            if (rsp_tdata[13:8] !== want.pos) begin
               $error("byte_position: expected %0d, got %0d", want.pos, rsp_tdata[13:8]);
               errors++;
            end
            if (rsp_tdata[20:14] !== want.len) begin
               $error("frame_length: expected %0d, got %0d", want.len, rsp_tdata[20:14]);
               errors++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

endmodule
